@@ design/gfde_pkg.sv @@
package gfde_pkg;

  localparam int unsigned SCREEN_WIDTH  = 1200;
  localparam int unsigned SCREEN_HEIGHT = 825;

  localparam int unsigned LANES      = 16;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned GROUP_W    = 8;
  localparam int unsigned LANE_IDX_W = 4;
  localparam int unsigned COL_W      = GROUP_W + LANE_IDX_W;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned AREA_X_W   = 11;
  localparam int unsigned AREA_Y_W   = 10;
  localparam int unsigned TIME_W     = 7;
  localparam int unsigned WORD_W     = LANES * CODE_W;
  localparam int unsigned HALF_W     = WORD_W / 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CODE_W-1:0] CODE_DARKEN = 2'b01;
  localparam logic [CODE_W-1:0] CODE_NONE   = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_MODE  = 3'd0,
    REG_FRAME_LEVEL = 3'd1,
    REG_AREA_X      = 3'd2,
    REG_AREA_WIDTH  = 3'd3,
    REG_AREA_Y      = 3'd4,
    REG_AREA_HEIGHT = 3'd5
  } cfg_reg_e;

  // per-pass settings shared by all lanes
  typedef struct packed {
    logic               two_bit;
    logic [LEVEL_W-1:0] thr;
    logic [COL_W-1:0]   col_lo;
    logic [COL_W-1:0]   col_hi;
  } lane_cfg_t;

  // contrast tables, indexed by threshold (frame level, saturated at 3 in two-bit mode)
  function automatic logic [TIME_W-1:0] row_time_f(input logic two_bit,
                                                   input logic [LEVEL_W-1:0] level);
    logic [TIME_W-1:0] t;
    t = '0;
    if (two_bit) begin
      case (level)
        4'd0, 4'd1: t = 7'd100;
        4'd2:       t = 7'd10;
        default:    t = 7'd8;
      endcase
    end else begin
      case (level)
        4'd0, 4'd1: t = 7'd50;
        4'd2:       t = 7'd30;
        4'd3:       t = 7'd10;
        4'd4, 4'd5, 4'd6: t = 7'd5;
        4'd7, 4'd8: t = 7'd4;
        4'd9, 4'd10, 4'd11: t = 7'd3;
        default:    t = 7'd2;
      endcase
    end
    return t;
  endfunction

endpackage

@@ design/grayscale_frame_drive_encoder.sv @@
// Results are valid in the cycle after acceptance. Throughput: one
// 16-pixel group per cycle while ready; all 16 lanes evaluate the
// group at once and a single output register holds the merged word.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset (async, active low) empties the output register and loads the
// register defaults; the config port always accepts.
module grayscale_frame_drive_encoder
  import gfde_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ROW_W-1:0]      row_index_i,
  input  logic [GROUP_W-1:0]    column_group_i,
  input  logic [LANES*LEVEL_W-1:0] pixel_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_W-1:0]     drive_word_o,
  output logic                  row_skipped_o,
  output logic [TIME_W-1:0]     row_time_o
);

  logic                depth_mode_q;
  logic [LEVEL_W-1:0]  frame_level_q;
  logic [AREA_X_W-1:0] area_x_q, area_width_q;
  logic [AREA_Y_W-1:0] area_y_q, area_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q  <= 1'b0;
      frame_level_q <= 4'd15;
      area_x_q      <= '0;
      area_width_q  <= AREA_X_W'(SCREEN_WIDTH);
      area_y_q      <= '0;
      area_height_q <= AREA_Y_W'(SCREEN_HEIGHT);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEPTH_MODE:  depth_mode_q  <= cfg_data_i[0];
        REG_FRAME_LEVEL: frame_level_q <= cfg_data_i[LEVEL_W-1:0];
        REG_AREA_X:      area_x_q      <= cfg_data_i[AREA_X_W-1:0];
        REG_AREA_WIDTH:  area_width_q  <= cfg_data_i[AREA_X_W-1:0];
        REG_AREA_Y:      area_y_q      <= cfg_data_i[AREA_Y_W-1:0];
        REG_AREA_HEIGHT: area_height_q <= cfg_data_i[AREA_Y_W-1:0];
        default: ;
      endcase
    end
  end

  lane_cfg_t           lane_cfg;
  logic [AREA_Y_W:0]   row_hi;
  logic                skip;
  logic [TIME_W-1:0]   row_time;
  logic [WORD_W-1:0]   codes;

  always_comb begin
    lane_cfg.two_bit = depth_mode_q;
    lane_cfg.thr     = (depth_mode_q && frame_level_q > 4'd3) ? 4'd3 : frame_level_q;
    lane_cfg.col_lo  = COL_W'(area_x_q);
    lane_cfg.col_hi  = COL_W'(area_x_q) + COL_W'(area_width_q);
  end

  assign row_hi   = (AREA_Y_W+1)'(area_y_q) + (AREA_Y_W+1)'(area_height_q);
  assign skip     = (row_index_i < area_y_q) ||
                    ({1'b0, row_index_i} >= row_hi) ||
                    ({1'b0, row_index_i} >= (ROW_W+1)'(SCREEN_HEIGHT));
  assign row_time = row_time_f(depth_mode_q, lane_cfg.thr);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gfde_lane u_lane (
      .cfg_i   (lane_cfg),
      .col_i   ({column_group_i, LANE_IDX_W'(i)}),
      .level_i (pixel_levels_i[i*LEVEL_W +: LEVEL_W]),
      .code_o  (codes[i*CODE_W +: CODE_W])
    );
  end

  gfde_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .codes_i       (codes),
    .skip_i        (skip),
    .time_i        (row_time),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_word_o  (drive_word_o),
    .row_skipped_o (row_skipped_o),
    .row_time_o    (row_time_o)
  );

endmodule

@@ design/gfde_lane.sv @@
module gfde_lane
  import gfde_pkg::*;
(
  input  lane_cfg_t          cfg_i,
  input  logic [COL_W-1:0]   col_i,
  input  logic [LEVEL_W-1:0] level_i,
  output logic [CODE_W-1:0]  code_o
);

  logic [LEVEL_W-1:0] level_used;
  logic               in_area;

  assign level_used = cfg_i.two_bit ? {2'b00, level_i[LEVEL_W-1:LEVEL_W-2]} : level_i;

  // one extra bit so a screen width equal to 2^COL_W still compares right
  assign in_area = (col_i >= cfg_i.col_lo) && (col_i < cfg_i.col_hi) &&
                   ({1'b0, col_i} < (COL_W+1)'(SCREEN_WIDTH));

  assign code_o = (in_area && (level_used < cfg_i.thr)) ? CODE_DARKEN : CODE_NONE;

endmodule

@@ design/gfde_merge.sv @@
module gfde_merge
  import gfde_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [WORD_W-1:0] codes_i,
  input  logic              skip_i,
  input  logic [TIME_W-1:0] time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] drive_word_o,
  output logic              row_skipped_o,
  output logic [TIME_W-1:0] row_time_o
);

  logic              valid_d, valid_q;
  logic [WORD_W-1:0] word_d, word_q;
  logic              skip_d, skip_q;
  logic [TIME_W-1:0] time_d, time_q;
  logic              accept;

  assign ready_o = !valid_q || out_ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    skip_d  = skip_q;
    time_d  = time_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      skip_d  = skip_i;
      if (skip_i) begin
        word_d = '0;
        time_d = '0;
      end else begin
        // halfword swap for the serial FIFO
        word_d = {codes_i[HALF_W-1:0], codes_i[WORD_W-1:HALF_W]};
        time_d = time_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    skip_q <= skip_d;
    time_q <= time_d;
  end

  assign out_valid_o   = valid_q;
  assign drive_word_o  = word_q;
  assign row_skipped_o = skip_q;
  assign row_time_o    = time_q;

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q)
    else $error("accepted request did not reach the output register");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && valid_q && !out_ready_i))
    else $error("stalled result overwritten");

  a_skip_null : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && skip_q) |-> (word_q == '0 && time_q == '0))
    else $error("skipped row carries data");

  a_time_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !skip_q) |-> (time_q != '0))
    else $error("drawn row without drive time");

endmodule
